/* rtl/scope_ring_capture_buffer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Scope ring capture buffer assertion macros
// Shared concurrent assertion forms used by the capture buffer top level.
// ----------------------------------------------------------------------------
`ifndef SCOPE_RING_CAPTURE_BUFFER_UNIT_DEFINES_SVH
`define SCOPE_RING_CAPTURE_BUFFER_UNIT_DEFINES_SVH

// An implication that is checked on every rising clock edge outside reset.
`define SRCB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srcb assertion failed");

// An implication whose consequence is checked at the next clock edge.
`define SRCB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srcb assertion failed");

`endif

/* rtl/srcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scope ring capture buffer package
// Sizes, action codes, pipeline stage types and the mix reciprocal table.
// ----------------------------------------------------------------------------
package srcb_pkg;

    localparam int DEPTH        = 2048;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int READ_MARGIN  = 64;
    localparam int MAX_CHANNELS = 4;
    localparam int NUM_CH       = 4;
    localparam int SAMPLE_W     = 24;
    localparam int LEN_W        = 16;
    localparam int CNT_W        = 3;
    localparam int SUM_W        = SAMPLE_W + 2;
    localparam int RECIP_W      = 17;
    localparam int FRAC_W       = 16;
    localparam int PROD_W       = SUM_W + RECIP_W + 1;
    localparam int CH_RESET     = 2;

    localparam logic [1:0] ACT_MONO    = 2'd0;
    localparam logic [1:0] ACT_MIX     = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    typedef struct packed {
        logic                     is_read;
        logic                     ok;
        logic [ADDR_W-1:0]        addr;
        logic signed [SUM_W-1:0]  sum;
        logic [RECIP_W-1:0]       recip;
    } t_s1;

    typedef struct packed {
        logic                     is_read;
        logic                     ok;
        logic [ADDR_W-1:0]        addr;
        logic signed [PROD_W-1:0] prod;
    } t_s2;

    // Reciprocal of the channel count in unsigned Q1.16, truncated.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21845;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13107;
            4'd6:    r = 17'd10922;
            4'd7:    r = 17'd9362;
            4'd8:    r = 17'd8192;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

/* rtl/scope_ring_capture_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scope ring capture buffer unit
// Oscilloscope capture ring with mono, mixed and silence writes and window reads.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle while o_in_ready is high (the clear pass and a
// stalled read result hold it low), writes and reads mixed freely; a read result
// is presented once its beat has passed r_s1, r_s2 and its RAM access. All samples
// live in one single-port RAM; every beat takes its one RAM access in the third
// pipeline stage, so accesses happen in arrival order and a read always sees the
// writes accepted before it. After reset the RAM is cleared in one pass over all
// 2048 addresses with no beat accepted; configuration writes are taken at any time.

`include "scope_ring_capture_buffer_unit_defines.svh"

module scope_ring_capture_buffer_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [srcb_pkg::CNT_W-1:0]             i_cfg_channel_count,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_action,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch0,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch1,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch2,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch3,
    input  logic [srcb_pkg::NUM_CH-1:0]            i_channel_present,
    input  logic                                   i_block_end,
    input  logic [srcb_pkg::LEN_W-1:0]             i_window_length,
    input  logic [srcb_pkg::LEN_W-1:0]             i_window_index,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [srcb_pkg::SAMPLE_W-1:0]   o_read_sample,
    output logic                                   o_read_ok
);

    localparam int AW = srcb_pkg::ADDR_W;
    localparam int SW = srcb_pkg::SAMPLE_W;

    logic [srcb_pkg::CNT_W-1:0] r_chan_cnt;
    logic [AW-1:0]              r_wr_ptr;
    logic [AW-1:0]              r_pub_ptr;
    logic                       r_active;
    logic [AW-1:0]              r_clr_cnt;
    logic                       r_clr_done;

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    srcb_pkg::t_s1              r_s1;
    srcb_pkg::t_s2              r_s2;
    logic                       r_ok3;

    srcb_pkg::t_s1              n_s1;
    logic [AW:0]                len_c;
    logic [AW-1:0]              n_wr_ptr;
    logic signed [srcb_pkg::SUM_W-1:0] mix_sum;
    logic [srcb_pkg::RECIP_W-1:0]      mix_recip;

    logic                       in_acc;
    logic                       wr_acc;
    logic                       mv3;
    logic                       go2;
    logic                       mv1;
    logic                       free1;

    logic signed [srcb_pkg::PROD_W-srcb_pkg::FRAC_W-1:0] q;
    logic signed [SW-1:0]       sat;

    logic                       ram_en;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [SW-1:0]              ram_wdata;
    logic [SW-1:0]              ram_rdata;

    assign o_cfg_ready = 1'b1;

    assign mv3        = !r_v3 || i_out_ready;
    assign go2        = r_v2 && (!r_s2.is_read || mv3);
    assign mv1        = r_v1 && (!r_v2 || go2);
    assign free1      = !r_v1 || mv1;
    assign o_in_ready = r_clr_done && free1;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_acc     = in_acc && (i_action != srcb_pkg::ACT_READ);

    srcb_mix u_mix (
        .i_action          (i_action),
        .i_channel_count   (r_chan_cnt),
        .i_sample_ch0      (i_sample_ch0),
        .i_sample_ch1      (i_sample_ch1),
        .i_sample_ch2      (i_sample_ch2),
        .i_sample_ch3      (i_sample_ch3),
        .i_channel_present (i_channel_present),
        .o_sum             (mix_sum),
        .o_recip           (mix_recip)
    );

    assign n_wr_ptr = r_wr_ptr + 1'b1;

    always_comb begin
        if (i_window_length > srcb_pkg::LEN_W'(srcb_pkg::DEPTH)) begin
            len_c = (AW+1)'(srcb_pkg::DEPTH);
        end else begin
            len_c = i_window_length[AW:0];
        end
        n_s1.is_read = (i_action == srcb_pkg::ACT_READ);
        n_s1.sum     = mix_sum;
        n_s1.recip   = mix_recip;
        if (n_s1.is_read) begin
            n_s1.ok   = r_active && (len_c != '0)
                        && (i_window_index < srcb_pkg::LEN_W'(len_c));
            n_s1.addr = r_pub_ptr - AW'(srcb_pkg::READ_MARGIN) - len_c[AW-1:0]
                        + i_window_index[AW-1:0];
        end else begin
            n_s1.ok   = 1'b0;
            n_s1.addr = r_wr_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= srcb_pkg::CNT_W'(srcb_pkg::CH_RESET);
            r_wr_ptr   <= '0;
            r_pub_ptr  <= '0;
            r_active   <= 1'b0;
            r_clr_cnt  <= '0;
            r_clr_done <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_chan_cnt <= i_cfg_channel_count;
            end
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(srcb_pkg::DEPTH - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (in_acc && i_action != srcb_pkg::ACT_READ) begin
                r_wr_ptr <= n_wr_ptr;
                if (i_block_end) begin
                    r_pub_ptr <= n_wr_ptr;
                    r_active  <= 1'b1;
                end
            end
            if (free1) begin
                r_v1 <= in_acc;
            end
            if (!r_v2 || go2) begin
                r_v2 <= mv1;
            end
            if (go2 && r_s2.is_read) begin
                r_v3 <= 1'b1;
            end else if (i_out_ready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (mv1) begin
            r_s2.is_read <= r_s1.is_read;
            r_s2.ok      <= r_s1.ok;
            r_s2.addr    <= r_s1.addr;
            r_s2.prod    <= srcb_pkg::PROD_W'(r_s1.sum)
                            * $signed({1'b0, r_s1.recip});
        end
        if (go2 && r_s2.is_read) begin
            r_ok3 <= r_s2.ok;
        end
    end

    always_comb begin
        q = r_s2.prod[srcb_pkg::PROD_W-1:srcb_pkg::FRAC_W];
        if (q > $signed((srcb_pkg::PROD_W-srcb_pkg::FRAC_W)'(2**(SW-1) - 1))) begin
            sat = {1'b0, {(SW-1){1'b1}}};
        end else if (q < -$signed((srcb_pkg::PROD_W-srcb_pkg::FRAC_W)'(2**(SW-1)))) begin
            sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            sat = q[SW-1:0];
        end
    end

    always_comb begin
        if (!r_clr_done) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = r_clr_cnt;
            ram_wdata = '0;
        end else begin
            ram_en    = go2;
            ram_we    = !r_s2.is_read;
            ram_addr  = r_s2.addr;
            ram_wdata = sat;
        end
    end

    srcb_ram #(
        .WIDTH (SW),
        .DEPTH (srcb_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid   = r_v3;
    assign o_read_ok     = r_v3 && r_ok3;
    assign o_read_sample = (r_v3 && r_ok3) ? ram_rdata : '0;

    `SRCB_ASSERT_IMPL(a_no_beat_during_clear, i_clk, i_rst_n, in_acc, r_clr_done)
    `SRCB_ASSERT_NEXT(a_rdata_held_on_stall, i_clk, i_rst_n, r_v3 && !i_out_ready, $stable(ram_rdata))
    `SRCB_ASSERT_NEXT(a_wr_ptr_step, i_clk, i_rst_n, wr_acc, r_wr_ptr == AW'($past(r_wr_ptr) + 1'b1))

endmodule

/* rtl/srcb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module srcb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/srcb_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scope ring capture buffer sample mixer
// Forms the channel sum and the reciprocal factor for each write beat.
// ----------------------------------------------------------------------------
module srcb_mix (
    input  logic [1:0]                             i_action,
    input  logic [srcb_pkg::CNT_W-1:0]             i_channel_count,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch0,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch1,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch2,
    input  logic signed [srcb_pkg::SAMPLE_W-1:0]   i_sample_ch3,
    input  logic [srcb_pkg::NUM_CH-1:0]            i_channel_present,
    output logic signed [srcb_pkg::SUM_W-1:0]      o_sum,
    output logic [srcb_pkg::RECIP_W-1:0]           o_recip
);

    logic signed [srcb_pkg::SAMPLE_W-1:0] samples [srcb_pkg::NUM_CH];
    logic [3:0]                           n;
    logic signed [srcb_pkg::SUM_W-1:0]    mix_sum;

    assign samples[0] = i_sample_ch0;
    assign samples[1] = i_sample_ch1;
    assign samples[2] = i_sample_ch2;
    assign samples[3] = i_sample_ch3;

    always_comb begin
        if (i_channel_count == '0) begin
            n = 4'd1;
        end else if (int'(i_channel_count) > srcb_pkg::MAX_CHANNELS) begin
            n = 4'(srcb_pkg::MAX_CHANNELS);
        end else begin
            n = 4'(i_channel_count);
        end
        mix_sum = '0;
        for (int c = 0; c < srcb_pkg::NUM_CH; c++) begin
            if (c < int'(n) && i_channel_present[c]) begin
                mix_sum = mix_sum + srcb_pkg::SUM_W'(samples[c]);
            end
        end
    end

    always_comb begin
        case (i_action)
            srcb_pkg::ACT_MONO: begin
                o_sum   = srcb_pkg::SUM_W'(i_sample_ch0);
                o_recip = srcb_pkg::recip_of(4'd1);
            end
            srcb_pkg::ACT_MIX: begin
                o_sum   = mix_sum;
                o_recip = srcb_pkg::recip_of(n);
            end
            default: begin
                o_sum   = '0;
                o_recip = srcb_pkg::recip_of(4'd1);
            end
        endcase
    end

endmodule

/* sim/scope_ring_capture_buffer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scope ring capture buffer unit testbench
// A queue-fed driver offers write and read beats with random gaps, while a
// receiver with random and long back-pressure takes the read results. Every
// accepted beat updates a behavioral copy of the capture ring, and every read
// result is compared field by field with the oldest predicted window sample.
// The channel count register is set to 0, 1, 3, 4, 7, 5 and 2 between phases.
// ----------------------------------------------------------------------------
module scope_ring_capture_buffer_unit_tb;
    import srcb_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int HOLD_CYCLES = 300;
    localparam logic [ADDR_W-1:0] PTR_MASK = ADDR_W'(DEPTH - 1);

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [SAMPLE_W-1:0] ch0;
        logic signed [SAMPLE_W-1:0] ch1;
        logic signed [SAMPLE_W-1:0] ch2;
        logic signed [SAMPLE_W-1:0] ch3;
        logic [NUM_CH-1:0]          present;
        logic                       block_end;
        logic [LEN_W-1:0]           win_len;
        logic [LEN_W-1:0]           win_idx;
    } capture_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       ok;
    } window_sample_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CNT_W-1:0]           i_cfg_channel_count = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [1:0]                 i_action = ACT_MONO;
    logic signed [SAMPLE_W-1:0] i_sample_ch0 = '0;
    logic signed [SAMPLE_W-1:0] i_sample_ch1 = '0;
    logic signed [SAMPLE_W-1:0] i_sample_ch2 = '0;
    logic signed [SAMPLE_W-1:0] i_sample_ch3 = '0;
    logic [NUM_CH-1:0]          i_channel_present = '0;
    logic                       i_block_end = 1'b0;
    logic [LEN_W-1:0]           i_window_length = '0;
    logic [LEN_W-1:0]           i_window_index = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_read_sample;
    logic                       o_read_ok;

    capture_beat_t  pending_beats[$];
    window_sample_t expected_reads[$];

    logic signed [SAMPLE_W-1:0] ring_store [DEPTH];
    logic [ADDR_W-1:0]          ring_working = '0;
    logic [ADDR_W-1:0]          ring_published = '0;
    logic                       ring_active = 1'b0;
    logic [CNT_W-1:0]           ring_channels = CNT_W'(CH_RESET);

    logic in_fire = 1'b0;
    bit   no_idle = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   stall_left = 0;
    int   stalls_asked = 0;
    int   stalls_granted = 0;
    int   error_count = 0;
    wire  hold_active = (stall_left != 0);

    scope_ring_capture_buffer_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_channel_count (i_cfg_channel_count),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_sample_ch0        (i_sample_ch0),
        .i_sample_ch1        (i_sample_ch1),
        .i_sample_ch2        (i_sample_ch2),
        .i_sample_ch3        (i_sample_ch3),
        .i_channel_present   (i_channel_present),
        .i_block_end         (i_block_end),
        .i_window_length     (i_window_length),
        .i_window_index      (i_window_index),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_read_sample       (o_read_sample),
        .o_read_ok           (o_read_ok)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            ring_store[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] mix_average(input capture_beat_t b,
                                                               input logic [CNT_W-1:0] count);
        int unsigned n;
        longint sum;
        longint prod;
        longint q;
        logic signed [SAMPLE_W-1:0] ch [NUM_CH];
        n = 32'(count);
        if (n < 1) n = 1;
        if (n > MAX_CHANNELS) n = MAX_CHANNELS;
        ch[0] = b.ch0;
        ch[1] = b.ch1;
        ch[2] = b.ch2;
        ch[3] = b.ch3;
        sum = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            if (c < n && b.present[c]) sum += longint'(ch[c]);
        end
        prod = sum * longint'(65536 / n);
        q = prod >>> FRAC_W;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic track_beat(input capture_beat_t b);
        int unsigned len;
        int unsigned idx;
        int unsigned pos;
        window_sample_t r;
        logic signed [SAMPLE_W-1:0] v;
        if (b.action == ACT_READ) begin
            len = 32'(b.win_len);
            idx = 32'(b.win_idx);
            if (len > DEPTH) len = DEPTH;
            r = '0;
            if (ring_active && len > 0 && idx < len) begin
                pos = int'(ring_published) - READ_MARGIN - len + idx;
                r.sample = ring_store[pos[ADDR_W-1:0]];
                r.ok = 1'b1;
            end
            expected_reads.push_back(r);
        end else begin
            case (b.action)
                ACT_MONO: v = b.ch0;
                ACT_MIX:  v = mix_average(b, ring_channels);
                default:  v = '0;
            endcase
            ring_store[ring_working] = v;
            ring_working = (ring_working + 1'b1) & PTR_MASK;
            if (b.block_end) begin
                ring_published = ring_working;
                ring_active = 1'b1;
            end
        end
    endtask

    function automatic capture_beat_t make_beat(input logic [1:0] action,
                                                input int s0, input int s1,
                                                input int s2, input int s3,
                                                input int present, input int blk,
                                                input int len, input int idx);
        capture_beat_t b;
        b.action = action;
        b.ch0 = s0[SAMPLE_W-1:0];
        b.ch1 = s1[SAMPLE_W-1:0];
        b.ch2 = s2[SAMPLE_W-1:0];
        b.ch3 = s3[SAMPLE_W-1:0];
        b.present = present[NUM_CH-1:0];
        b.block_end = blk[0];
        b.win_len = len[LEN_W-1:0];
        b.win_idx = idx[LEN_W-1:0];
        return b;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic capture_beat_t random_beat(input int read_pct);
        capture_beat_t b;
        int pick;
        int len;
        b.ch0 = random_sample();
        b.ch1 = random_sample();
        b.ch2 = random_sample();
        b.ch3 = random_sample();
        b.present = NUM_CH'($urandom);
        b.win_len = LEN_W'($urandom);
        b.win_idx = LEN_W'($urandom);
        b.block_end = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 99);
        if (pick < read_pct) begin
            b.action = ACT_READ;
            b.block_end = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 65535;
                2, 3: len = $urandom_range(0, 65535);
                default: len = $urandom_range(1, 256);
            endcase
            b.win_len = len[LEN_W-1:0];
            if (len > 0 && $urandom_range(0, 3) != 0) begin
                if (len > DEPTH) len = DEPTH;
                b.win_idx = LEN_W'($urandom_range(0, len - 1));
            end
        end else if (pick < read_pct + (100 - read_pct) / 2) begin
            b.action = ACT_MIX;
        end else if (pick < 95) begin
            b.action = ACT_MONO;
        end else begin
            b.action = ACT_SILENCE;
        end
        return b;
    endfunction

    task automatic queue_random(input int count, input int read_pct);
        for (int i = 0; i < count; i++) begin
            pending_beats.push_back(random_beat(read_pct));
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_beats.size() != 0 || i_in_valid || expected_reads.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_channel_count(input logic [CNT_W-1:0] n);
        @(negedge i_clk);
        i_cfg_channel_count <= n;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin : drive_beats
        capture_beat_t b;
        if (i_in_valid && !in_fire) begin
            // Beat still waiting for acceptance; hold payload.
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            i_action <= b.action;
            i_sample_ch0 <= b.ch0;
            i_sample_ch1 <= b.ch1;
            i_sample_ch2 <= b.ch2;
            i_sample_ch3 <= b.ch3;
            i_channel_present <= b.present;
            i_block_end <= b.block_end;
            i_window_length <= b.win_len;
            i_window_index <= b.win_idx;
            i_in_valid <= 1'b1;
            if (!no_idle && !hold_active && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 9);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stalls_granted != stalls_asked) begin
            stalls_granted++;
            stall_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 9);
        end
    end

    always @(posedge i_clk) begin : observe
        capture_beat_t b;
        window_sample_t want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("unexpected result, read_sample",
                                    longint'(o_read_sample), longint'(0));
                end else begin
                    want = expected_reads.pop_front();
                    if (o_read_sample !== want.sample)
                        report_mismatch("read_sample", longint'(o_read_sample),
                                        longint'(want.sample));
                    if (o_read_ok !== want.ok)
                        report_mismatch("read_ok", longint'(o_read_ok), longint'(want.ok));
                end
            end
            if (i_cfg_valid && o_cfg_ready) ring_channels = i_cfg_channel_count;
            if (i_in_valid && o_in_ready) begin
                b.action = i_action;
                b.ch0 = i_sample_ch0;
                b.ch1 = i_sample_ch1;
                b.ch2 = i_sample_ch2;
                b.ch3 = i_sample_ch3;
                b.present = i_channel_present;
                b.block_end = i_block_end;
                b.win_len = i_window_length;
                b.win_idx = i_window_index;
                track_beat(b);
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reads before any block end, extreme writes, and window edge cases.
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 16, 0));
        pending_beats.push_back(make_beat(ACT_MONO, 8388607, 0, 0, 0, 0, 0, 65535, 65535));
        pending_beats.push_back(make_beat(ACT_MONO, -8388608, -1, -1, -1, 15, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_MIX, 8388607, 8388607, 8388607, 8388607,
                                          15, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_MIX, -8388608, -8388608, -8388608, -8388608,
                                          15, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_MIX, 1000, -3, 77, 9, 5, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_MIX, -7, 12345, -1, 1, 10, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_SILENCE, 8388607, 8388607, 1, 1, 15, 0, 5, 5));
        pending_beats.push_back(make_beat(ACT_MONO, 24'h123456, 0, 0, 0, 0, 1, 65535, 0));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 65535, 65535));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 65535, 2047));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 2049, 2048));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 2048, 2047));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 70, 69));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 70, 70));
        pending_beats.push_back(make_beat(ACT_READ, -1, -1, -1, -1, 15, 1, 1, 0));
        pending_beats.push_back(make_beat(ACT_MONO, 42, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 2048, 2044));
        wait_drained();

        write_channel_count(3'd0);
        pending_beats.push_back(make_beat(ACT_MIX, 8388607, 8388607, 0, 0, 15, 1, 0, 0));
        queue_random(60, 45);
        wait_drained();

        write_channel_count(3'd1);
        queue_random(55, 45);
        wait_drained();

        write_channel_count(3'd3);
        stalls_asked++;
        queue_random(50, 80);
        wait_drained();

        write_channel_count(3'd4);
        queue_random(30, 45);
        wait_drained();
        queue_random(30, 45);
        wait_drained();

        write_channel_count(3'd7);
        pending_beats.push_back(make_beat(ACT_MIX, -8388608, -8388608, -8388608, -8388608,
                                          15, 1, 0, 0));
        queue_random(60, 45);
        wait_drained();

        write_channel_count(3'd5);
        queue_random(55, 45);
        wait_drained();

        write_channel_count(3'd2);
        no_idle = 1'b1;
        queue_random(60, 45);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("scope_ring_capture_buffer_unit_tb: clean");
        end else begin
            $display("scope_ring_capture_buffer_unit_tb: errors");
        end
        $finish;
    end

    initial begin
        #(400000 * CLK_PERIOD);
        $display("scope_ring_capture_buffer_unit_tb: errors");
        $finish;
    end

endmodule
